### rtl/awob_pkg.sv
// Package for the additive wavetable oscillator bank: widths, register and
// wave codes, reset values and the interpolated sine table.
// No dependencies.
package awob_pkg;

   // Sine table, TABLE_SIZE entries of Q1.15, indexed by the top phase bits
   localparam int TABLE_LOG2 = 6;
   localparam int TABLE_SIZE = 1 << TABLE_LOG2;

   localparam int MAX_HARMONICS_DEF = 16;

   localparam int PHASE_W = 32;
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W = 16;

   // Shared divider: dividend holds a raw weight shifted up 15 plus half the sum
   localparam int DVD_W = 46;
   localparam int DVS_W = 33;
   localparam int RAW_W = 31;
   localparam int WGT_W = 16;

   // Shared multiplier and accumulator
   localparam int ACC_W = 34;
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 17;
   localparam int PROD_W = MUL_A_W + MUL_B_W;

   // Register indexes
   localparam logic [1:0] CSR_WAVE_TYPE = 2'd0;
   localparam logic [1:0] CSR_HARM_COUNT = 2'd1;
   localparam logic [1:0] CSR_OUTPUT_GAIN = 2'd2;

   // Wave codes
   localparam logic [1:0] WAVE_TRIANGLE = 2'd0;
   localparam logic [1:0] WAVE_SQUARE = 2'd1;
   localparam logic [1:0] WAVE_SAW_UP = 2'd2;
   localparam logic [1:0] WAVE_SAW_DOWN = 2'd3;

   localparam logic [1:0] WAVE_RESET = WAVE_TRIANGLE;
   localparam logic [4:0] COUNT_RESET = 5'd1;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;
   localparam logic [PHASE_W-1:0] PHASE_QUARTER = 32'h4000_0000;

   typedef logic signed [SAMPLE_W-1:0] sine_rom_type [TABLE_SIZE];

   // sin(pi/2 * u) in Q30 for u in Q30, odd polynomial
   function automatic longint unsigned sine_q30(input longint unsigned u);
      longint unsigned u2;
      longint unsigned p;
      u2 = (u * u) >> 30;
      p = 64'd3864;
      p = 64'd172271 - ((u2 * p) >> 30);
      p = 64'd5026995 - ((u2 * p) >> 30);
      p = 64'd85569306 - ((u2 * p) >> 30);
      p = 64'd693598747 - ((u2 * p) >> 30);
      p = 64'd1686629713 - ((u2 * p) >> 30);
      return (u * p) >> 30;
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint unsigned r;
      longint unsigned q;
      longint unsigned u;
      longint unsigned mag;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         r = 64'(4 * i);
         q = r / TABLE_SIZE;
         u = ((r % TABLE_SIZE) << 30) / TABLE_SIZE;
         if (q[0]) begin
            u = (64'd1 << 30) - u;
         end
         mag = (sine_q30(u) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (mag > 64'd32767) begin
            mag = 64'd32767;
         end
         rom[i] = (q >= 64'd2) ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

### rtl/awob_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on awob_pkg for the operand widths.
module awob_div
   import awob_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   rem_sub;
   logic             fits;

   assign rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};
   assign fits = (rem_sh >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
      end else if (busy_ff) begin
         // shift the quotient bit in where the dividend bit leaves
         rem_in = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quotient = dvd_ff;

endmodule

### rtl/awob_phase_store.sv
// Phase accumulator store: one write and one registered read a cycle, with
// a valid bit per entry, so a clear empties all at once. Depends on awob_pkg.
module awob_phase_store
   import awob_pkg::*;
#(
   parameter int DEPTH = MAX_HARMONICS_DEF,
   parameter int AW = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [PHASE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [PHASE_W-1:0] rd_data,
   output logic               rd_valid
);

   logic [PHASE_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [PHASE_W-1:0] rd_data_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // an entry never written since the last clear or reset reads with rd_valid low
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

### rtl/additive_wavetable_oscillator_bank_core.sv
// Additive wavetable oscillator bank, top level: sequencer, shared multiplier,
// weight memory and output register. Depends on awob_pkg, awob_div and
// awob_phase_store.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-------------------------------------
//   req     | in        | req_valid/req_ready  | fundamental_step, envelope_gain
//   rsp     | out       | rsp_valid/rsp_ready  | sample_out
//   csr     | in        | csr_write_en only    | index 0 wave, 1 count, 2 gain
//
// One word is handled at a time, N being the partials in use: the single multiplier
// forms two products per partial (table interpolation, then weighting); then the
// last term is added, output and envelope gains are applied, and the result is
// rounded and saturated. After reset and after every write of wave_type or
// harmonic_count the bank rebuilds its weights with the serial divider, during
// which req_ready stays low. A stalled result is held in the output register;
// the next word is taken meanwhile and waits in the final stage.
module additive_wavetable_oscillator_bank_core
   import awob_pkg::*;
#(
   parameter int MAX_HARMONICS = MAX_HARMONICS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [PHASE_W-1:0]         req_fundamental_step,
   input  logic [GAIN_W-1:0]          req_envelope_gain,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_write_en,
   input  logic [1:0]                 csr_index,
   input  logic [GAIN_W-1:0]          csr_wdata
);

   localparam int K_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
   localparam int H_W = $clog2(2 * MAX_HARMONICS);
   localparam int T_W = ACC_W - 15;
   localparam int Y_W = PROD_W - 29;

   // sequencer states
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_RAW_GO    = 4'd1;
   localparam logic [3:0] ST_RAW_WAIT  = 4'd2;
   localparam logic [3:0] ST_NORM_RD   = 4'd3;
   localparam logic [3:0] ST_NORM_GO   = 4'd4;
   localparam logic [3:0] ST_NORM_WAIT = 4'd5;
   localparam logic [3:0] ST_RD        = 4'd6;
   localparam logic [3:0] ST_INTERP    = 4'd7;
   localparam logic [3:0] ST_WEIGHT    = 4'd8;
   localparam logic [3:0] ST_LAST      = 4'd9;
   localparam logic [3:0] ST_GAIN      = 4'd10;
   localparam logic [3:0] ST_ENV       = 4'd11;
   localparam logic [3:0] ST_OUT       = 4'd12;

   // configuration registers
   logic [1:0]        wave_type_ff;
   logic [4:0]        harmonic_count_ff;
   logic [GAIN_W-1:0] output_gain_ff;
   logic              mode_write;

   // sequencer registers
   logic [3:0]                 state_ff, state_in;
   logic [K_W-1:0]             k_ff, k_in;
   logic [DVS_W-1:0]           sum_ff, sum_in;
   logic [PHASE_W-1:0]         inc_ff, inc_in;
   logic [PHASE_W-1:0]         inc_step_ff, inc_step_in;
   logic [GAIN_W-1:0]          env_ff, env_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] a_ff, a_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   // derived control
   logic [6:0]     count_ext;
   logic [6:0]     active_n;
   logic [K_W-1:0] last_k;
   logic           odd_only;
   logic           triangle;
   logic           saw_up;

   // divider
   logic             div_start;
   logic [DVD_W-1:0] div_dividend;
   logic [DVS_W-1:0] div_divisor;
   logic             div_done;
   logic [DVD_W-1:0] div_quotient;
   logic [H_W-1:0]   h_num;
   logic [2*H_W-1:0] h_sq;

   // weight memory and phase store
   logic [RAW_W-1:0]   weight_mem_ff [MAX_HARMONICS];
   logic [RAW_W-1:0]   w_rd_ff;
   logic               wmem_we;
   logic               rd_en;
   logic [K_W-1:0]     rd_addr;
   logic [PHASE_W-1:0] ph_rd_data;
   logic               ph_rd_valid;
   logic [PHASE_W-1:0] phase_cur;
   logic [PHASE_W-1:0] phase_next;
   logic               ph_wr_en;

   // lookup and arithmetic
   logic [TABLE_LOG2-1:0]      tbl_idx;
   logic [TABLE_LOG2-1:0]      tbl_nxt;
   logic [15:0]                frac;
   logic signed [SAMPLE_W-1:0] rom_a;
   logic signed [SAMPLE_W-1:0] rom_b;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [SAMPLE_W:0]   val17;
   logic signed [SAMPLE_W-1:0] val16;
   logic signed [ACC_W-1:0]    prod_acc;
   logic signed [ACC_W-1:0]    term;
   logic signed [ACC_W-1:0]    acc_round;
   logic signed [T_W-1:0]      t_val;
   logic signed [PROD_W-1:0]   y_round;
   logic signed [Y_W-1:0]      y_full;
   logic signed [SAMPLE_W-1:0] y_sat;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic                       mul_en;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [PROD_W-1:0]   prod_ff;

   // ---------------------------------------------------------------------
   // Configuration: a wave or count write restarts the weight build and
   // drops every phase back to its start value.
   // ---------------------------------------------------------------------
   assign mode_write = csr_write_en &&
                       ((csr_index == CSR_WAVE_TYPE) || (csr_index == CSR_HARM_COUNT));

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_type_ff <= WAVE_RESET;
         harmonic_count_ff <= COUNT_RESET;
         output_gain_ff <= GAIN_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WAVE_TYPE:   wave_type_ff <= csr_wdata[1:0];
            CSR_HARM_COUNT:  harmonic_count_ff <= csr_wdata[4:0];
            CSR_OUTPUT_GAIN: output_gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the count into 1..MAX_HARMONICS
   always_comb begin
      count_ext = {2'b00, harmonic_count_ff};
      if (count_ext == 7'd0) begin
         active_n = 7'd1;
      end else if (count_ext > 7'(MAX_HARMONICS)) begin
         active_n = 7'(MAX_HARMONICS);
      end else begin
         active_n = count_ext;
      end
   end

   assign last_k = K_W'(active_n - 7'd1);
   assign triangle = (wave_type_ff == WAVE_TRIANGLE);
   assign odd_only = (wave_type_ff == WAVE_TRIANGLE) || (wave_type_ff == WAVE_SQUARE);
   assign saw_up = (wave_type_ff == WAVE_SAW_UP);

   // ---------------------------------------------------------------------
   // Weight build: first pass divides 2^30 by n or n^2 into raw weights and
   // sums them; second pass normalises each raw weight against the sum.
   // ---------------------------------------------------------------------
   assign h_num = odd_only ? H_W'({k_ff, 1'b1}) : (H_W'(k_ff) + H_W'(1));
   assign h_sq = h_num * h_num;

   always_comb begin
      div_start = 1'b0;
      div_dividend = DVD_W'(1) << 30;
      div_divisor = triangle ? DVS_W'(h_sq) : DVS_W'(h_num);
      if (state_ff == ST_RAW_GO) begin
         div_start = 1'b1;
      end else if (state_ff == ST_NORM_GO) begin
         div_start = 1'b1;
         div_dividend = DVD_W'({w_rd_ff, 15'b0}) + DVD_W'(sum_ff >> 1);
         div_divisor = sum_ff;
      end
   end

   awob_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign wmem_we = div_done && ((state_ff == ST_RAW_WAIT) || (state_ff == ST_NORM_WAIT));

   // Read port is shared by the normalise pass and the sample loop; in the
   // weighting cycle fetch the next partial ahead.
   assign rd_en = (state_ff == ST_NORM_RD) || (state_ff == ST_RD) ||
                  ((state_ff == ST_WEIGHT) && (k_ff != last_k));
   assign rd_addr = (state_ff == ST_WEIGHT) ? (k_ff + 1'b1) : k_ff;

   always_ff @(posedge clock) begin
      if (wmem_we) begin
         weight_mem_ff[k_ff] <= div_quotient[RAW_W-1:0];
      end
      if (rd_en) begin
         w_rd_ff <= weight_mem_ff[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Phase accumulators
   // ---------------------------------------------------------------------
   assign ph_wr_en = (state_ff == ST_INTERP);
   assign phase_cur = ph_rd_valid ? ph_rd_data : (triangle ? PHASE_QUARTER : '0);
   assign phase_next = phase_cur + inc_ff;

   awob_phase_store #(
      .DEPTH (MAX_HARMONICS),
      .AW    (K_W)
   ) u_phase (
      .clock    (clock),
      .reset    (reset),
      .clear    (mode_write),
      .wr_en    (ph_wr_en),
      .wr_addr  (k_ff),
      .wr_data  (phase_next),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (ph_rd_data),
      .rd_valid (ph_rd_valid)
   );

   // ---------------------------------------------------------------------
   // Table lookup; the next index wraps so the last segment runs to entry 0
   // ---------------------------------------------------------------------
   assign tbl_idx = phase_cur[PHASE_W-1 -: TABLE_LOG2];
   assign tbl_nxt = tbl_idx + 1'b1;
   assign frac = phase_cur[PHASE_W-1-TABLE_LOG2 -: 16];
   assign rom_a = SINE_ROM[tbl_idx];
   assign rom_b = SINE_ROM[tbl_nxt];
   assign diff = {rom_b[SAMPLE_W-1], rom_b} - {rom_a[SAMPLE_W-1], rom_a};

   // interpolated value: a plus floor of the scaled slope
   assign val17 = {a_ff[SAMPLE_W-1], a_ff} + prod_ff[32:16];
   assign val16 = val17[SAMPLE_W-1:0];

   // weighted partial; saw up flips every weight
   assign prod_acc = prod_ff[ACC_W-1:0];
   assign term = saw_up ? -prod_acc : prod_acc;

   assign acc_round = acc_ff + ACC_W'(2 ** 14);
   assign t_val = acc_round[ACC_W-1:15];

   assign y_round = prod_ff + PROD_W'(2 ** 28);
   assign y_full = y_round[PROD_W-1:29];

   always_comb begin
      if (y_full > Y_W'(32767)) begin
         y_sat = 16'sh7FFF;
      end else if (y_full < -Y_W'(32768)) begin
         y_sat = 16'sh8000;
      end else begin
         y_sat = y_full[SAMPLE_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Shared multiplier: operands chosen by state, product registered
   // ---------------------------------------------------------------------
   always_comb begin
      mul_en = 1'b1;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_INTERP: begin
            mul_a = MUL_A_W'(diff);
            mul_b = {1'b0, frac};
         end
         ST_WEIGHT: begin
            mul_a = MUL_A_W'(val16);
            mul_b = {1'b0, w_rd_ff[WGT_W-1:0]};
         end
         ST_GAIN: begin
            mul_a = MUL_A_W'(t_val);
            mul_b = {1'b0, output_gain_ff};
         end
         ST_ENV: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = {1'b0, env_ff};
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_p;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      sum_in = sum_ff;
      inc_in = inc_ff;
      inc_step_in = inc_step_ff;
      env_in = env_ff;
      acc_in = acc_ff;
      a_in = a_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // partial k steps by fundamental_step times its harmonic number
               k_in = '0;
               inc_in = req_fundamental_step;
               inc_step_in = odd_only ? (req_fundamental_step << 1) : req_fundamental_step;
               env_in = req_envelope_gain;
               acc_in = '0;
               state_in = ST_RD;
            end
         end
         ST_RAW_GO: begin
            state_in = ST_RAW_WAIT;
         end
         ST_RAW_WAIT: begin
            if (div_done) begin
               sum_in = sum_ff + DVS_W'(div_quotient[RAW_W-1:0]);
               if (k_ff == last_k) begin
                  k_in = '0;
                  state_in = ST_NORM_RD;
               end else begin
                  k_in = k_ff + 1'b1;
                  state_in = ST_RAW_GO;
               end
            end
         end
         ST_NORM_RD: begin
            state_in = ST_NORM_GO;
         end
         ST_NORM_GO: begin
            state_in = ST_NORM_WAIT;
         end
         ST_NORM_WAIT: begin
            if (div_done) begin
               if (k_ff == last_k) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
                  state_in = ST_NORM_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            // fold in the previous partial's weighted value
            if (k_ff != '0) begin
               acc_in = acc_ff + term;
            end
            a_in = rom_a;
            state_in = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            inc_in = inc_ff + inc_step_ff;
            if (k_ff == last_k) begin
               state_in = ST_LAST;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = ST_INTERP;
            end
         end
         ST_LAST: begin
            acc_in = acc_ff + term;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            state_in = ST_ENV;
         end
         ST_ENV: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold here while the previous sample still waits
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sample_in = y_sat;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (mode_write) begin
         state_in = ST_RAW_GO;
         k_in = '0;
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RAW_GO;
         k_ff <= '0;
         sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         sum_ff <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inc_ff <= inc_in;
      inc_step_ff <= inc_step_in;
      env_ff <= env_in;
      acc_ff <= acc_in;
      a_ff <= a_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

`ifndef ASSERT_OFF
   a_accept_starts_loop: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !mode_write) |=> (state_ff == ST_RD))
      else $error("accepted word did not start the partial loop");

   a_loop_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_INTERP) || (state_ff == ST_WEIGHT)) |-> (k_ff <= last_k))
      else $error("partial index beyond the active count");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output stage");

   a_rebuild_blocks_req: assert property (@(posedge clock) disable iff (reset)
      mode_write |=> !req_ready)
      else $error("input taken while weights are rebuilt");
`endif

endmodule
